// File: rtl/eft_pkg.sv
`timescale 1ns / 1ps

package eft_pkg;

	// Defaults for the top level parameters
	localparam int FLAG_WORDS_DEF  = 3;
	localparam int WAITER_BITS_DEF = 8;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Bits in one flag word
	localparam int WORD_BITS = 64;

	// Command codes as they arrive in the func field
	localparam logic [2:0] FUNC_ALLOC   = 3'd0;
	localparam logic [2:0] FUNC_FREE    = 3'd1;
	localparam logic [2:0] FUNC_SET     = 3'd2;
	localparam logic [2:0] FUNC_CLEAR   = 3'd3;
	localparam logic [2:0] FUNC_WAIT    = 3'd4;
	localparam logic [2:0] FUNC_HANDLER = 3'd5;

	// Result codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_ALREADY_SET = 3'd1;
	localparam logic [2:0] ST_REGISTERED  = 3'd2;
	localparam logic [2:0] ST_EXHAUSTED   = 3'd3;
	localparam logic [2:0] ST_OUT_OF_RANGE = 3'd4;
	localparam logic [2:0] ST_WAITER_BUSY = 3'd5;

	// Command class decided by the front end
	typedef enum logic [2:0] {
		K_ALLOC,
		K_FREE,
		K_SET,
		K_CLEAR,
		K_WAIT,
		K_HANDLER,
		K_BAD
	} kind_t;

	// Back end sequencer states
	typedef enum logic [1:0] {
		B_IDLE,
		B_EXEC,
		B_SEARCH
	} back_state_t;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] event_index;
		logic [7:0] waiter_id;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] alloc_index;
		logic       wake_valid;
		logic [7:0] wake_waiter;
	} rsp_t;

	typedef struct packed {
		logic       found;
		logic [5:0] idx;
	} hit_t;

	// Lowest set bit of a flag word: isolate it, then encode the one-hot
	function automatic hit_t lowest_set(input logic [WORD_BITS-1:0] v);
		logic [WORD_BITS-1:0] onehot;
		hit_t h;
		onehot = v & (~v + 64'd1);
		h.found = |v;
		h.idx = '0;
		for (int k = 0; k < 6; k++) begin
			for (int b = 0; b < WORD_BITS; b++) begin
				if (((b >> k) & 1) == 1) begin
					h.idx[k] = h.idx[k] | onehot[b];
				end
			end
		end
		return h;
	endfunction

endpackage

// File: rtl/event_flag_table.sv
`timescale 1ns / 1ps

// Event flag table: 64*FLAG_WORDS flags with alloc, free, set, clear, wait and
// handler registration, one result per command, in command order. A command
// is taken into a QUEUE_DEPTH-entry queue as soon as there is room, so the input
// side keeps moving while a result waits on the output. The back end reads the
// waiter RAM as a command leaves the queue, then applies the command and
// registers its result; alloc instead scans one 64-bit word of the allocation
// map per cycle, up to min(FLAG_WORDS,4) words, until it finds a free event.
// The next command leaves the queue only once the current result is registered.
// No clearing pass is needed after reset.
module event_flag_table #(
	parameter int FLAG_WORDS  = eft_pkg::FLAG_WORDS_DEF,
	parameter int WAITER_BITS = eft_pkg::WAITER_BITS_DEF,
	parameter int QUEUE_DEPTH = eft_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  eft_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output eft_pkg::rsp_t rsp
);

	localparam int EVENT_COUNT = eft_pkg::WORD_BITS * FLAG_WORDS;
	localparam int EVW = $clog2(EVENT_COUNT);
	localparam int QW = 3 + EVW + WAITER_BITS;

	logic          q_full;
	logic          push;
	logic [QW-1:0] push_data;
	logic          pop;
	logic          q_valid;
	logic [QW-1:0] q_data;

	eft_front #(
		.FLAG_WORDS (FLAG_WORDS),
		.WAITER_BITS(WAITER_BITS)
	) u_front (
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.q_full   (q_full),
		.push     (push),
		.push_data(push_data)
	);

	eft_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_data   (q_data)
	);

	eft_back #(
		.FLAG_WORDS (FLAG_WORDS),
		.WAITER_BITS(WAITER_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.pop      (pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

// File: rtl/eft_ram.sv
`timescale 1ns / 1ps

module eft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/eft_front.sv
`timescale 1ns / 1ps

module eft_front #(
	parameter int FLAG_WORDS  = eft_pkg::FLAG_WORDS_DEF,
	parameter int WAITER_BITS = eft_pkg::WAITER_BITS_DEF,
	localparam int EVENT_COUNT = eft_pkg::WORD_BITS * FLAG_WORDS,
	localparam int EVW = $clog2(EVENT_COUNT),
	localparam int QW = 3 + EVW + WAITER_BITS
) (
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  eft_pkg::cmd_t cmd,
	input  logic          q_full,
	output logic          push,
	output logic [QW-1:0] push_data
);

	logic [9:0]     ev_ext;
	logic [15:0]    wid_ext;
	logic           in_range;
	eft_pkg::kind_t kind;

	assign ev_ext   = 10'(cmd.event_index);
	assign wid_ext  = 16'(cmd.waiter_id);
	assign in_range = ev_ext < 10'(EVENT_COUNT);

	// Sort the command; bad codes and out of range events go as one class
	always_comb begin
		case (cmd.func)
			eft_pkg::FUNC_ALLOC:   kind = eft_pkg::K_ALLOC;
			eft_pkg::FUNC_FREE:    kind = in_range ? eft_pkg::K_FREE : eft_pkg::K_BAD;
			eft_pkg::FUNC_SET:     kind = in_range ? eft_pkg::K_SET : eft_pkg::K_BAD;
			eft_pkg::FUNC_CLEAR:   kind = in_range ? eft_pkg::K_CLEAR : eft_pkg::K_BAD;
			eft_pkg::FUNC_WAIT:    kind = in_range ? eft_pkg::K_WAIT : eft_pkg::K_BAD;
			eft_pkg::FUNC_HANDLER: kind = in_range ? eft_pkg::K_HANDLER : eft_pkg::K_BAD;
			default:               kind = eft_pkg::K_BAD;
		endcase
	end

	// Transfer into the queue whenever there is room
	assign cmd_stall = q_full;
	assign push      = cmd_valid && !q_full;
	assign push_data = {kind, ev_ext[EVW-1:0], wid_ext[WAITER_BITS-1:0]};

endmodule

// File: rtl/eft_queue.sv
`timescale 1ns / 1ps

module eft_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = eft_pkg::QUEUE_DEPTH_DEF,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             q_valid,
	output logic [WIDTH-1:0] q_data
);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    count_q;

	// Pointer step with wrap at the depth
	function automatic logic [PW-1:0] step(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= step(wr_q);
			end
			if (pop) begin
				rd_q <= step(rd_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	assign full    = count_q == CW'(DEPTH);
	assign q_valid = count_q != '0;
	assign q_data  = entry_q[rd_q];

endmodule

// File: rtl/eft_back.sv
`timescale 1ns / 1ps

module eft_back #(
	parameter int FLAG_WORDS  = eft_pkg::FLAG_WORDS_DEF,
	parameter int WAITER_BITS = eft_pkg::WAITER_BITS_DEF,
	localparam int EVENT_COUNT = eft_pkg::WORD_BITS * FLAG_WORDS,
	localparam int EVW = $clog2(EVENT_COUNT),
	localparam int QW = 3 + EVW + WAITER_BITS,
	// alloc only hands out events that an 8 bit index can name
	localparam int SEARCH_WORDS = (FLAG_WORDS < 4) ? FLAG_WORDS : 4,
	localparam int WW = (SEARCH_WORDS > 1) ? $clog2(SEARCH_WORDS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  logic [QW-1:0] q_data,
	output logic          pop,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output eft_pkg::rsp_t rsp
);

	eft_pkg::back_state_t state_q, state_d;

	// Command being carried out
	eft_pkg::kind_t         kind_q;
	logic [EVW-1:0]         ev_q;
	logic [WAITER_BITS-1:0] wid_q;
	logic [WW-1:0]          word_q;

	// Event state
	logic [EVENT_COUNT-1:0] alloc_q;
	logic [EVENT_COUNT-1:0] raised_q;
	logic [EVENT_COUNT-1:0] present_q;
	logic [EVENT_COUNT-1:0] handler_q;

	eft_pkg::rsp_t rsp_q, rsp_d;
	logic          rsp_valid_q;

	logic                   out_free;
	logic                   done;
	logic                   last_word;
	eft_pkg::hit_t          hit;
	logic [EVW-1:0]         alloc_ev;
	logic [EVW-1:0]         tgt;
	logic [WAITER_BITS-1:0] ident;
	logic [15:0]            ident_ext;
	logic [15:0]            wid_ext;
	logic                   ram_we;
	logic                   ram_re;
	logic                   set_alloc, clr_alloc;
	logic                   set_raised, clr_raised;
	logic                   set_present, clr_present;
	logic                   handler_d;
	eft_pkg::kind_t         head_kind;
	logic [EVW-1:0]         head_ev;

	assign head_kind = eft_pkg::kind_t'(q_data[QW-1 -: 3]);
	assign head_ev   = q_data[EVW+WAITER_BITS-1 -: EVW];

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign hit       = eft_pkg::lowest_set(~alloc_q[word_q*eft_pkg::WORD_BITS +: eft_pkg::WORD_BITS]);
	assign alloc_ev  = EVW'({word_q, hit.idx});
	assign last_word = word_q == WW'(SEARCH_WORDS - 1);
	assign ident_ext = 16'(ident);
	assign wid_ext   = 16'(wid_q);

	// Waiter identifiers live in RAM, read as the command leaves the queue
	eft_ram #(
		.WIDTH(WAITER_BITS),
		.DEPTH(EVENT_COUNT)
	) u_ident (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ev_q),
		.wdata(wid_q),
		.re   (ram_re),
		.raddr(head_ev),
		.rdata(ident)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			eft_pkg::B_IDLE: begin
				if (q_valid) begin
					state_d = (head_kind == eft_pkg::K_ALLOC) ? eft_pkg::B_SEARCH
					                                          : eft_pkg::B_EXEC;
				end
			end
			eft_pkg::B_EXEC: begin
				if (out_free) begin
					state_d = eft_pkg::B_IDLE;
				end
			end
			eft_pkg::B_SEARCH: begin
				if ((hit.found || last_word) && out_free) begin
					state_d = eft_pkg::B_IDLE;
				end
			end
			default: state_d = eft_pkg::B_IDLE;
		endcase
	end

	// Outputs: result and state updates of the current command
	always_comb begin
		pop         = 1'b0;
		ram_re      = 1'b0;
		ram_we      = 1'b0;
		done        = 1'b0;
		tgt         = ev_q;
		set_alloc   = 1'b0;
		clr_alloc   = 1'b0;
		set_raised  = 1'b0;
		clr_raised  = 1'b0;
		set_present = 1'b0;
		clr_present = 1'b0;
		handler_d   = 1'b0;
		rsp_d       = '0;
		case (state_q)
			eft_pkg::B_IDLE: begin
				pop    = q_valid;
				ram_re = q_valid;
			end
			eft_pkg::B_EXEC: begin
				done = out_free;
				case (kind_q)
					eft_pkg::K_FREE: begin
						clr_alloc = 1'b1;
					end
					eft_pkg::K_SET: begin
						set_raised = 1'b1;
						if (present_q[ev_q]) begin
							rsp_d.wake_valid  = 1'b1;
							rsp_d.wake_waiter = ident_ext[7:0];
							clr_present       = !handler_q[ev_q];
							handler_d         = handler_q[ev_q];
						end
					end
					eft_pkg::K_CLEAR: begin
						clr_raised = 1'b1;
					end
					eft_pkg::K_WAIT: begin
						if (raised_q[ev_q]) begin
							rsp_d.status = eft_pkg::ST_ALREADY_SET;
						end else if (present_q[ev_q]) begin
							rsp_d.status = eft_pkg::ST_WAITER_BUSY;
						end else begin
							rsp_d.status = eft_pkg::ST_REGISTERED;
							set_present  = 1'b1;
							ram_we       = out_free;
						end
					end
					eft_pkg::K_HANDLER: begin
						if (present_q[ev_q]) begin
							rsp_d.status = eft_pkg::ST_WAITER_BUSY;
						end else begin
							set_present = 1'b1;
							handler_d   = 1'b1;
							ram_we      = out_free;
							if (raised_q[ev_q]) begin
								rsp_d.status      = eft_pkg::ST_ALREADY_SET;
								rsp_d.wake_valid  = 1'b1;
								rsp_d.wake_waiter = wid_ext[7:0];
							end else begin
								rsp_d.status = eft_pkg::ST_REGISTERED;
							end
						end
					end
					default: begin
						rsp_d.status = eft_pkg::ST_OUT_OF_RANGE;
					end
				endcase
			end
			eft_pkg::B_SEARCH: begin
				tgt = alloc_ev;
				if (hit.found) begin
					done              = out_free;
					set_alloc         = 1'b1;
					clr_raised        = 1'b1;
					clr_present       = 1'b1;
					rsp_d.alloc_index = 8'({word_q, hit.idx});
				end else if (last_word) begin
					done         = out_free;
					rsp_d.status = eft_pkg::ST_EXHAUSTED;
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// Sequencer, event state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= eft_pkg::B_IDLE;
			word_q      <= '0;
			alloc_q     <= '0;
			raised_q    <= '0;
			present_q   <= '0;
			handler_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				word_q <= '0;
			end else if (state_q == eft_pkg::B_SEARCH && !hit.found && !last_word) begin
				word_q <= word_q + 1'b1;
			end
			if (done) begin
				if (set_alloc) begin
					alloc_q[tgt] <= 1'b1;
				end else if (clr_alloc) begin
					alloc_q[tgt] <= 1'b0;
				end
				if (set_raised) begin
					raised_q[tgt] <= 1'b1;
				end else if (clr_raised) begin
					raised_q[tgt] <= 1'b0;
				end
				if (set_present) begin
					present_q[tgt] <= 1'b1;
					handler_q[tgt] <= handler_d;
				end else if (clr_present) begin
					present_q[tgt] <= 1'b0;
					handler_q[tgt] <= 1'b0;
				end
			end
			if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Command and result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= head_kind;
			ev_q   <= head_ev;
			wid_q  <= q_data[WAITER_BITS-1:0];
		end
		if (done) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/eft_checker.sv
`timescale 1ns / 1ps

module eft_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_stall,
	input eft_pkg::cmd_t cmd,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input eft_pkg::rsp_t rsp
);

	// A stalled result stays offered until its transfer
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// Only a successful alloc reports a nonzero event number
	a_alloc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.alloc_index != 8'd0 |->
			rsp.status == eft_pkg::ST_OK && !rsp.wake_valid)
		else $error("alloc index with bad status or a wake");

	// A wake comes only with ok or already set, and no wake carries no id
	a_wake: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.wake_valid &&
			(rsp.status == eft_pkg::ST_OK || rsp.status == eft_pkg::ST_ALREADY_SET)) ||
			(!rsp.wake_valid && rsp.wake_waiter == 8'd0))
		else $error("inconsistent wake report");

	// Result codes stay within the defined set
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status <= eft_pkg::ST_WAITER_BUSY)
		else $error("undefined result code");

endmodule

bind event_flag_table eft_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_stall(cmd_stall),
	.cmd      (cmd),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

// File: dv/event_flag_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the event flag table, keeps its own copy of the
// flag, allocation and waiter state, and compares every response transfer
// against the oldest predicted one.
module event_flag_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  logic          cmd_stall,
	input  eft_pkg::cmd_t cmd,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  eft_pkg::rsp_t rsp,
	output int unsigned   errors,
	output int unsigned   results_seen,
	output int unsigned   pending
);
	import eft_pkg::*;

	localparam int EVENTS = FLAG_WORDS_DEF * WORD_BITS;
	localparam logic [7:0] WAITER_MASK = 8'((1 << WAITER_BITS_DEF) - 1);

	// Shadow state of the table
	logic [EVENTS-1:0] ev_owned = '0;
	logic [EVENTS-1:0] ev_raised = '0;
	bit                waiter_on  [EVENTS];
	bit                waiter_hdl [EVENTS];
	logic [7:0]        waiter_who [EVENTS];

	rsp_t expected_q [$];

	// Apply one command to the shadow state, give back the response it earns
	function automatic rsp_t apply_cmd(input cmd_t c);
		rsp_t r;
		logic [7:0] wid;
		int ev;
		bit found;
		r = '0;
		wid = c.waiter_id & WAITER_MASK;
		ev = c.event_index;
		found = 1'b0;
		if (c.func == FUNC_ALLOC) begin
			// lowest free event, with its flag and waiter wiped
			for (int e = 0; e < EVENTS && e < 256; e++) begin
				if (!found && !ev_owned[e]) begin
					found = 1'b1;
					ev_owned[e] = 1'b1;
					ev_raised[e] = 1'b0;
					waiter_on[e] = 1'b0;
					waiter_hdl[e] = 1'b0;
					r.alloc_index = 8'(e);
				end
			end
			r.status = found ? ST_OK : ST_EXHAUSTED;
		end else if (c.func > FUNC_HANDLER || ev >= EVENTS) begin
			r.status = ST_OUT_OF_RANGE;
		end else begin
			r.status = ST_OK;
			case (c.func)
				FUNC_FREE: begin
					ev_owned[ev] = 1'b0;
				end
				FUNC_SET: begin
					ev_raised[ev] = 1'b1;
					if (waiter_on[ev]) begin
						r.wake_valid = 1'b1;
						r.wake_waiter = waiter_who[ev];
						// one-shot waiters go, handlers stay
						if (!waiter_hdl[ev])
							waiter_on[ev] = 1'b0;
					end
				end
				FUNC_CLEAR: begin
					ev_raised[ev] = 1'b0;
				end
				FUNC_WAIT: begin
					if (ev_raised[ev]) begin
						r.status = ST_ALREADY_SET;
					end else if (waiter_on[ev]) begin
						r.status = ST_WAITER_BUSY;
					end else begin
						waiter_on[ev] = 1'b1;
						waiter_hdl[ev] = 1'b0;
						waiter_who[ev] = wid;
						r.status = ST_REGISTERED;
					end
				end
				default: begin
					// handler: busy check comes before the raised flag
					if (waiter_on[ev]) begin
						r.status = ST_WAITER_BUSY;
					end else begin
						waiter_on[ev] = 1'b1;
						waiter_hdl[ev] = 1'b1;
						waiter_who[ev] = wid;
						if (ev_raised[ev]) begin
							r.status = ST_ALREADY_SET;
							r.wake_valid = 1'b1;
							r.wake_waiter = wid;
						end else begin
							r.status = ST_REGISTERED;
						end
					end
				end
			endcase
		end
		return r;
	endfunction

	// Responses are checked before the command of the same edge is modelled
	always @(posedge clk) begin : watch
		rsp_t want;
		int unsigned bad;
		bad = 0;
		if (!arst_n) begin
			errors <= 0;
			results_seen <= 0;
			pending <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_q.size() == 0) begin
					$error("response transfer with no command outstanding");
					bad++;
				end else begin
					want = expected_q.pop_front();
					if (rsp.status !== want.status) begin
						$error("status expected %0d actual %0d", want.status, rsp.status);
						bad++;
					end
					if (rsp.alloc_index !== want.alloc_index) begin
						$error("alloc_index expected %0d actual %0d",
							want.alloc_index, rsp.alloc_index);
						bad++;
					end
					if (rsp.wake_valid !== want.wake_valid) begin
						$error("wake_valid expected %0d actual %0d",
							want.wake_valid, rsp.wake_valid);
						bad++;
					end
					if (rsp.wake_waiter !== want.wake_waiter) begin
						$error("wake_waiter expected %0d actual %0d",
							want.wake_waiter, rsp.wake_waiter);
						bad++;
					end
				end
				results_seen <= results_seen + 1;
			end
			if (cmd_valid && !cmd_stall)
				expected_q.push_back(apply_cmd(cmd));
			errors <= errors + bad;
			pending <= expected_q.size();
		end
	end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the event flag table; all checking lives in the
// checker instance beside the block and in the assertions bound into it.
module testbench;
	import eft_pkg::*;

	// func codes the block does not know
	localparam logic [2:0] FUNC_BAD_LO = 3'd6;
	localparam logic [2:0] FUNC_BAD_HI = 3'd7;

	localparam int RANDOM_ITEMS = 900;

	// random phase styles
	typedef enum int {
		PH_FILL,
		PH_DRAIN,
		PH_MIX
	} phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int unsigned errors;
	int unsigned results_seen;
	int unsigned pending;
	int unsigned sent = 0;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;

	event_flag_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	event_flag_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.cmd          (cmd),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp),
		.errors       (errors),
		.results_seen (results_seen),
		.pending      (pending)
	);

	always #5 clk = ~clk;

	// Watchdog
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	// One command transfer, after a random gap unless the sender is in a burst
	task automatic push_cmd(input logic [2:0] f, input logic [7:0] ev, input logic [7:0] wid);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= '{func: f, event_index: ev, waiter_id: wid};
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		sent++;
	endtask

	// Hold the sender off until every response is back
	task automatic drain();
		cmd_valid <= 1'b0;
		while (results_seen < sent) @(posedge clk);
	endtask

	// Event number: half the time a few hot events so waits and sets meet
	function automatic logic [7:0] pick_event();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 8'($urandom_range(0, 7));
		else if (r < 5)
			return 8'($urandom_range(184, 191));
		else if (r < 9)
			return 8'($urandom_range(0, 191));
		return 8'($urandom_range(192, 255));
	endfunction

	function automatic logic [2:0] pick_func(input phase_t ph);
		int r;
		r = $urandom_range(0, 99);
		case (ph)
			PH_FILL: begin
				if (r < 85) return FUNC_ALLOC;
				if (r < 90) return FUNC_SET;
				if (r < 95) return FUNC_WAIT;
				return FUNC_HANDLER;
			end
			PH_DRAIN: begin
				if (r < 55) return FUNC_FREE;
				if (r < 65) return FUNC_SET;
				if (r < 75) return FUNC_CLEAR;
				if (r < 85) return FUNC_WAIT;
				if (r < 95) return FUNC_HANDLER;
				return FUNC_ALLOC;
			end
			default: begin
				if (r < 2) return FUNC_BAD_LO;
				if (r < 4) return FUNC_BAD_HI;
				if (r < 18) return FUNC_ALLOC;
				if (r < 30) return FUNC_FREE;
				if (r < 50) return FUNC_SET;
				if (r < 62) return FUNC_CLEAR;
				if (r < 82) return FUNC_WAIT;
				return FUNC_HANDLER;
			end
		endcase
	endfunction

	// Receiver: random stall before each response transfer
	initial begin : receiver
		int hold;
		@(posedge arst_n);
		forever begin
			hold = rx_quiet ? 0 : $urandom_range(0, 5);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!(rsp_valid && !rsp_stall));
		end
	end

	// Stimulus and verdict
	initial begin : stimulus
		int done;
		int span;
		phase_t ph;
		done = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: each command and its corner cases
		push_cmd(FUNC_ALLOC, 8'd0, 8'd0);
		push_cmd(FUNC_ALLOC, 8'd255, 8'd255);
		push_cmd(FUNC_WAIT, 8'd0, 8'hFF);       // registers
		push_cmd(FUNC_WAIT, 8'd0, 8'h12);       // waiter busy
		push_cmd(FUNC_SET, 8'd0, 8'd0);         // wakes the one-shot waiter
		push_cmd(FUNC_WAIT, 8'd0, 8'h34);       // flag already raised
		push_cmd(FUNC_HANDLER, 8'd0, 8'h00);    // registered and woken at once
		push_cmd(FUNC_SET, 8'd0, 8'd0);         // handler kept and woken again
		push_cmd(FUNC_CLEAR, 8'd0, 8'd0);
		push_cmd(FUNC_HANDLER, 8'd0, 8'h55);    // busy, checked first
		push_cmd(FUNC_FREE, 8'd0, 8'd0);        // flag and waiter left alone
		push_cmd(FUNC_ALLOC, 8'd0, 8'd0);       // hands out event 0 again, wiped
		push_cmd(FUNC_SET, 8'd191, 8'd0);       // unallocated event
		push_cmd(FUNC_SET, 8'd192, 8'd0);       // first out of range
		push_cmd(FUNC_CLEAR, 8'd255, 8'd255);
		push_cmd(FUNC_WAIT, 8'd200, 8'd1);
		push_cmd(FUNC_BAD_LO, 8'd3, 8'd3);
		push_cmd(FUNC_BAD_HI, 8'd255, 8'd255);
		push_cmd(FUNC_HANDLER, 8'd5, 8'hAA);
		push_cmd(FUNC_SET, 8'd5, 8'd0);
		push_cmd(FUNC_WAIT, 8'd191, 8'h77);
		push_cmd(FUNC_FREE, 8'd1, 8'd0);
		push_cmd(FUNC_FREE, 8'd191, 8'd0);      // free of an unallocated event
		drain();

		// random phases; the first fills the table well past exhaustion
		ph = PH_FILL;
		span = 260;
		while (done < RANDOM_ITEMS) begin
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < span; i++) begin
				push_cmd(pick_func(ph), pick_event(), 8'($urandom_range(0, 255)));
				done++;
			end
			drain();
			ph = phase_t'($urandom_range(0, 2));
			span = $urandom_range(60, 140);
		end

		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/eft_pkg.sv
rtl/eft_ram.sv
rtl/eft_front.sv
rtl/eft_queue.sv
rtl/eft_back.sv
rtl/event_flag_table.sv
rtl/eft_checker.sv
dv/event_flag_checker.sv
dv/testbench.sv
